// ===== rtl/nsfe_pkg.sv =====
// ---------------------------------------------------------------------------
// NMEA sentence field extractor package
// Character codes, sentence type codes, parser state encoding, the result
// record and the field lookup for GGA, GSV and RMC sentences.
// ---------------------------------------------------------------------------
package nsfe_pkg;

    // Framing and header characters.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_V      = 8'h56;

    // Sentence type codes.
    localparam logic [1:0] TYPE_NONE = 2'd0;
    localparam logic [1:0] TYPE_GGA  = 2'd1;
    localparam logic [1:0] TYPE_GSV  = 2'd2;
    localparam logic [1:0] TYPE_RMC  = 2'd3;

    // Sticky mask bits.
    localparam logic [2:0] SEEN_GGA = 3'h1;
    localparam logic [2:0] SEEN_GSV = 3'h2;
    localparam logic [2:0] SEEN_RMC = 3'h4;

    // Result kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Field identifiers.
    localparam logic [3:0] FLD_LAT     = 4'd0;
    localparam logic [3:0] FLD_LATDIR  = 4'd1;
    localparam logic [3:0] FLD_LON     = 4'd2;
    localparam logic [3:0] FLD_LONDIR  = 4'd3;
    localparam logic [3:0] FLD_FIX     = 4'd4;
    localparam logic [3:0] FLD_USED    = 4'd5;
    localparam logic [3:0] FLD_ALT     = 4'd6;
    localparam logic [3:0] FLD_VISIBLE = 4'd7;
    localparam logic [3:0] FLD_TIME    = 4'd8;
    localparam logic [3:0] FLD_SPEED   = 4'd9;
    localparam logic [3:0] FLD_COURSE  = 4'd10;
    localparam logic [3:0] FLD_DATE    = 4'd11;

    // Counters stop at this value.
    localparam logic [3:0] CNT_MAX = 4'd15;

    // Number of header characters kept in storage (the fifth is checked live).
    localparam int HDR_KEPT = 4;

    // Parser state, one-hot.
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_HEADER = 3'b010,
        MODE_DATA   = 3'b100
    } t_mode;

    // One result record.
    typedef struct packed {
        logic       result_kind;
        logic [3:0] field_id;
        logic [3:0] char_index;
        logic [7:0] char_value;
        logic [1:0] sentence_type;
        logic [2:0] valid_mask;
    } t_result;

    // Field lookup answer: whether the field is captured, its id and length.
    typedef struct packed {
        logic       hit;
        logic [3:0] id;
        logic [3:0] len;
    } t_field;

    // Captured field for a sentence type and comma count.
    function automatic t_field field_lookup(input logic [1:0] stype,
                                            input logic [3:0] comma);
        t_field f;
        f = '0;
        case (stype)
            TYPE_GSV: begin
                if (comma == 4'd3) begin
                    f.hit = 1'b1;
                    f.id  = FLD_VISIBLE;
                    f.len = 4'd2;
                end
            end
            TYPE_GGA: begin
                case (comma)
                    4'd2:    begin f.id = FLD_LAT;    f.len = 4'd9;  end
                    4'd3:    begin f.id = FLD_LATDIR; f.len = 4'd1;  end
                    4'd4:    begin f.id = FLD_LON;    f.len = 4'd10; end
                    4'd5:    begin f.id = FLD_LONDIR; f.len = 4'd1;  end
                    4'd6:    begin f.id = FLD_FIX;    f.len = 4'd1;  end
                    4'd7:    begin f.id = FLD_USED;   f.len = 4'd2;  end
                    4'd9:    begin f.id = FLD_ALT;    f.len = 4'd6;  end
                    default: begin f.id = FLD_LAT;    f.len = 4'd0;  end
                endcase
                f.hit = (f.len != 4'd0);
            end
            TYPE_RMC: begin
                case (comma)
                    4'd1:    begin f.id = FLD_TIME;   f.len = 4'd6;  end
                    4'd2:    begin f.id = FLD_FIX;    f.len = 4'd1;  end
                    4'd3:    begin f.id = FLD_LAT;    f.len = 4'd9;  end
                    4'd4:    begin f.id = FLD_LATDIR; f.len = 4'd1;  end
                    4'd5:    begin f.id = FLD_LON;    f.len = 4'd10; end
                    4'd6:    begin f.id = FLD_LONDIR; f.len = 4'd1;  end
                    4'd7:    begin f.id = FLD_SPEED;  f.len = 4'd5;  end
                    4'd8:    begin f.id = FLD_COURSE; f.len = 4'd5;  end
                    4'd9:    begin f.id = FLD_DATE;   f.len = 4'd6;  end
                    default: begin f.id = FLD_LAT;    f.len = 4'd0;  end
                endcase
                f.hit = (f.len != 4'd0);
            end
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/nsfe_parser.sv =====
// ---------------------------------------------------------------------------
// NMEA sentence parser core
// Holds the sentence state and decodes one character per step into at most
// one result record.
// ---------------------------------------------------------------------------
module nsfe_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output logic                o_emit,
    output nsfe_pkg::t_result   o_result
);

    nsfe_pkg::t_mode r_mode, n_mode;
    logic [1:0] r_type, n_type;
    logic [3:0] r_comma, n_comma;
    logic [3:0] r_count, n_count;
    logic [2:0] r_seen, n_seen;
    logic [7:0] r_hdr [nsfe_pkg::HDR_KEPT];

    nsfe_pkg::t_field w_field;
    logic             w_talker_ok;
    logic [1:0]       w_hdr_type;
    logic [3:0]       w_count_inc;
    logic [3:0]       w_comma_inc;

    // Saturating increments.
    assign w_count_inc = (r_count == nsfe_pkg::CNT_MAX) ? r_count : r_count + 4'd1;
    assign w_comma_inc = (r_comma == nsfe_pkg::CNT_MAX) ? r_comma : r_comma + 4'd1;

    // Header match, with the current character as the fifth header character.
    assign w_talker_ok = (r_hdr[0] == nsfe_pkg::CH_G || r_hdr[0] == nsfe_pkg::CH_B) &&
                         (r_hdr[1] == nsfe_pkg::CH_P || r_hdr[1] == nsfe_pkg::CH_D ||
                          r_hdr[1] == nsfe_pkg::CH_N);

    always_comb begin
        w_hdr_type = nsfe_pkg::TYPE_NONE;
        if (w_talker_ok) begin
            if (r_hdr[2] == nsfe_pkg::CH_G && r_hdr[3] == nsfe_pkg::CH_G &&
                i_byte == nsfe_pkg::CH_A) begin
                w_hdr_type = nsfe_pkg::TYPE_GGA;
            end else if (r_hdr[2] == nsfe_pkg::CH_G && r_hdr[3] == nsfe_pkg::CH_S &&
                         i_byte == nsfe_pkg::CH_V) begin
                w_hdr_type = nsfe_pkg::TYPE_GSV;
            end else if (r_hdr[2] == nsfe_pkg::CH_R && r_hdr[3] == nsfe_pkg::CH_M &&
                         i_byte == nsfe_pkg::CH_C) begin
                w_hdr_type = nsfe_pkg::TYPE_RMC;
            end
        end
    end

    assign w_field = nsfe_pkg::field_lookup(r_type, r_comma);

    // Next state and result for one character.
    always_comb begin
        n_mode   = r_mode;
        n_type   = r_type;
        n_comma  = r_comma;
        n_count  = r_count;
        n_seen   = r_seen;
        o_emit   = 1'b0;
        o_result = '0;

        if (i_byte == nsfe_pkg::CH_DOLLAR) begin
            n_type  = nsfe_pkg::TYPE_NONE;
            n_mode  = nsfe_pkg::MODE_HEADER;
            n_count = 4'd0;
        end else if (i_byte == nsfe_pkg::CH_COMMA) begin
            n_comma = w_comma_inc;
            n_count = 4'd0;
        end else if (i_byte == nsfe_pkg::CH_STAR) begin
            case (r_type)
                nsfe_pkg::TYPE_GGA: n_seen = r_seen | nsfe_pkg::SEEN_GGA;
                nsfe_pkg::TYPE_GSV: n_seen = r_seen | nsfe_pkg::SEEN_GSV;
                nsfe_pkg::TYPE_RMC: n_seen = r_seen | nsfe_pkg::SEEN_RMC;
                default:            n_seen = r_seen;
            endcase
            o_emit                 = 1'b1;
            o_result.result_kind   = nsfe_pkg::KIND_END;
            o_result.sentence_type = r_type;
            o_result.valid_mask    = n_seen;
            n_mode                 = nsfe_pkg::MODE_IDLE;
        end else begin
            n_count = w_count_inc;
            case (r_mode)
                nsfe_pkg::MODE_HEADER: begin
                    // The last header character completes the check.
                    if (r_count == 4'd4 && w_hdr_type != nsfe_pkg::TYPE_NONE) begin
                        n_type  = w_hdr_type;
                        n_mode  = nsfe_pkg::MODE_DATA;
                        n_comma = 4'd0;
                        n_count = 4'd0;
                    end
                end
                nsfe_pkg::MODE_DATA: begin
                    if (w_field.hit && r_count < w_field.len) begin
                        o_result.result_kind = nsfe_pkg::KIND_CHAR;
                        o_result.field_id    = w_field.id;
                        o_result.char_index  = r_count;
                        o_result.char_value  = i_byte;
                        o_emit               = 1'b1;
                        // RMC status becomes a fix flag; other characters drop.
                        if (r_type == nsfe_pkg::TYPE_RMC &&
                            w_field.id == nsfe_pkg::FLD_FIX) begin
                            o_result.char_value = (i_byte == nsfe_pkg::CH_A) ? 8'd1 : 8'd0;
                            o_emit = (i_byte == nsfe_pkg::CH_A) ||
                                     (i_byte == nsfe_pkg::CH_V);
                        end
                    end
                end
                default: ;
            endcase
        end

        if (!i_step) begin
            o_emit = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= nsfe_pkg::MODE_IDLE;
            r_type  <= nsfe_pkg::TYPE_NONE;
            r_comma <= 4'd0;
            r_count <= 4'd0;
            r_seen  <= 3'd0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_type  <= n_type;
            r_comma <= n_comma;
            r_count <= n_count;
            r_seen  <= n_seen;
        end
    end

    // Header character storage for the first four header positions.
    always_ff @(posedge i_clk) begin
        if (i_step && r_mode == nsfe_pkg::MODE_HEADER &&
            i_byte != nsfe_pkg::CH_DOLLAR && i_byte != nsfe_pkg::CH_COMMA &&
            i_byte != nsfe_pkg::CH_STAR && r_count < 4'd4) begin
            r_hdr[r_count[1:0]] <= i_byte;
        end
    end

endmodule

// ===== rtl/nmea_sentence_field_extractor.sv =====
// ---------------------------------------------------------------------------
// NMEA sentence field extractor
// Registers incoming characters, parses one per cycle while the output is free,
// and holds each result in an output register until the receiver takes it.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid/o_ready carry one character on i_rx_byte per
//   transaction. Output channel: o_valid/i_ready carry one result record per
//   transaction; a character may produce no result.
//   Throughput: one character per cycle while the receiver does not stall,
//   set by the combinational parser between the input and output registers.
//   Path: an accepted character is held in the input register until the
//   output can take its result; the parser decodes it combinationally into
//   the output register, which drives o_valid.
//   Reset (synchronous, i_rst_n low) returns the parser to idle, clears the
//   sentence type, both counters and the sticky mask, and empties both
//   registers. Header characters are not cleared; they are always written
//   before they are checked.
//   When the receiver stalls, the output register holds its record and an
//   empty input register still takes one more character; o_ready then drops
//   until the output drains.
// ---------------------------------------------------------------------------
module nmea_sentence_field_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_result_kind,
    output logic [3:0] o_field_id,
    output logic [3:0] o_char_index,
    output logic [7:0] o_char_value,
    output logic [1:0] o_sentence_type,
    output logic [2:0] o_valid_mask
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    nsfe_pkg::t_result r_out;

    logic              w_out_free;
    logic              w_step;
    logic              w_emit;
    nsfe_pkg::t_result w_result;

    // The parser advances when a character is held and the output can take it.
    assign w_out_free = !r_out_valid || i_ready;
    assign w_step     = r_in_valid && w_out_free;
    assign o_ready    = !r_in_valid || w_step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    nsfe_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_kind   = r_out.result_kind;
    assign o_field_id      = r_out.field_id;
    assign o_char_index    = r_out.char_index;
    assign o_char_value    = r_out.char_value;
    assign o_sentence_type = r_out.sentence_type;
    assign o_valid_mask    = r_out.valid_mask;

endmodule
